>>> rtl/crw_pkg.sv
// Shared types and constants for the character-word machine.
// No dependencies; the front end, back end, top level and testbench import this package.
package crw_pkg;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_STEP,
        OP_START
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_FETCH,
        BK_OPER
    } bstate_t;

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_HALT   = 3'd1;
    localparam logic [2:0] ST_GET    = 3'd2;
    localparam logic [2:0] ST_PUT    = 3'd3;
    localparam logic [2:0] ST_BADOP  = 3'd4;
    localparam logic [2:0] ST_BADARG = 3'd5;
    localparam logic [2:0] ST_IDLE   = 3'd6;

    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [6:0] BLOCK_WORDS = 7'd10;

    localparam logic [31:0] ZERO_CHARS = 32'h3030_3030;

    typedef struct packed {
        op_t         op;
        logic        addr_ok;
        logic [6:0]  address;
        logic [31:0] word;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data;
        logic [6:0]  block_address;
        logic [6:0]  next_counter;
        logic        compare_flag;
    } res_t;

endpackage

>>> rtl/crw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/crw_front.sv
// Front end: accepts host items, classifies them and queues them for the back end.
// Depends on crw_pkg.
module crw_front #(
    parameter int MEM_WORDS = 100
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_operation,
    input  logic [6:0]    s_address,
    input  logic [31:0]   s_word,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output crw_pkg::cmd_t cmd_data
);
    import crw_pkg::*;

    localparam logic [6:0] MEM_W7 = 7'(MEM_WORDS);

    cmd_t       q_reg [2];
    cmd_t       cls;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    always_comb begin
        cls.op      = op_t'(s_operation);
        cls.addr_ok = s_address < MEM_W7;
        cls.address = s_address;
        cls.word    = s_word;
    end

    assign s_ready   = cnt_reg != 2'd2;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd_data  = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> rtl/crw_back.sv
// Back end: executes queued items against the word memory and holds the result register.
// Depends on crw_pkg and crw_ram.
module crw_back #(
    parameter int MEM_WORDS = 100
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  crw_pkg::cmd_t cmd_data,
    output logic          m_valid,
    input  logic          m_ready,
    output crw_pkg::res_t m_res
);
    import crw_pkg::*;

    localparam int         AW     = $clog2(MEM_WORDS);
    localparam logic [6:0] MEM_W7 = 7'(MEM_WORDS);
    localparam logic [7:0] MEM_W8 = 8'(MEM_WORDS);

    bstate_t              state_reg, state_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic [31:0]          r_reg, r_next;
    logic [31:0]          ir_reg, ir_next;
    logic                 tog_reg, tog_next;
    logic                 run_reg, run_next;
    logic [MEM_WORDS-1:0] vld_reg, vld_next;
    logic                 vld_rd_reg;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg, res;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata, mem_word;

    logic        out_free, finish, fin_read;
    logic [2:0]  fin_status;
    logic [6:0]  fin_block;
    logic [31:0] fin_rdata;

    logic [7:0] op_ch, c2, c3;
    logic       digits_ok, op_known, is_lc;
    logic [6:0] base, arg, cnt_inc;

    crw_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mem_word = vld_rd_reg ? ram_rdata : 32'd0;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        op_ch     = mem_word[31:24];
        c2        = mem_word[15:8];
        c3        = mem_word[7:0];
        digits_ok = (c2 >= CH_ZERO) && (c2 <= CH_NINE) && (c3 >= CH_ZERO) && (c3 <= CH_NINE);
        op_known  = (op_ch == CH_L) || (op_ch == CH_S) || (op_ch == CH_C) ||
                    (op_ch == CH_B) || (op_ch == CH_G) || (op_ch == CH_P);
        base      = {3'b000, c2[3:0]} * BLOCK_WORDS;
        arg       = base + {3'b000, c3[3:0]};
        is_lc     = ((op_ch == CH_L) || (op_ch == CH_C)) && digits_ok && (arg < MEM_W7);
        cnt_inc   = cnt_reg + 7'd1;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        r_next     = r_reg;
        ir_next    = ir_reg;
        tog_next   = tog_reg;
        run_next   = run_reg;
        vld_next   = vld_reg;
        ram_we     = 1'b0;
        ram_waddr  = cmd_data.address[AW-1:0];
        ram_wdata  = cmd_data.word;
        ram_re     = 1'b0;
        ram_raddr  = cnt_reg[AW-1:0];
        cmd_ready  = 1'b0;
        finish     = 1'b0;
        fin_status = ST_DONE;
        fin_block  = 7'd0;
        fin_read   = 1'b0;
        fin_rdata  = 32'd0;

        unique case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd_data.op)
                        OP_WRITE: begin
                            if (out_free) begin
                                finish    = 1'b1;
                                cmd_ready = 1'b1;
                                if (cmd_data.addr_ok) begin
                                    ram_we = 1'b1;
                                    vld_next[cmd_data.address[AW-1:0]] = 1'b1;
                                end else begin
                                    fin_status = ST_BADARG;
                                end
                            end
                        end
                        OP_READ: begin
                            if (!cmd_data.addr_ok) begin
                                if (out_free) begin
                                    finish     = 1'b1;
                                    cmd_ready  = 1'b1;
                                    fin_read   = 1'b1;
                                    fin_status = ST_BADARG;
                                end
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = cmd_data.address[AW-1:0];
                                cmd_ready  = 1'b1;
                                state_next = BK_READ;
                            end
                        end
                        OP_START: begin
                            if (out_free) begin
                                finish    = 1'b1;
                                cmd_ready = 1'b1;
                                cnt_next  = 7'd0;
                                run_next  = 1'b1;
                            end
                        end
                        OP_STEP: begin
                            if (!run_reg) begin
                                if (out_free) begin
                                    finish     = 1'b1;
                                    cmd_ready  = 1'b1;
                                    fin_status = ST_IDLE;
                                end
                            end else if (cnt_reg >= MEM_W7) begin
                                if (out_free) begin
                                    finish     = 1'b1;
                                    cmd_ready  = 1'b1;
                                    fin_status = ST_BADARG;
                                    run_next   = 1'b0;
                                end
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = cnt_reg[AW-1:0];
                                cmd_ready  = 1'b1;
                                state_next = BK_FETCH;
                            end
                        end
                    endcase
                end
            end
            BK_READ: begin
                if (out_free) begin
                    finish     = 1'b1;
                    fin_read   = 1'b1;
                    fin_rdata  = mem_word;
                    state_next = BK_IDLE;
                end
            end
            BK_FETCH: begin
                if (is_lc) begin
                    ir_next    = mem_word;
                    cnt_next   = cnt_inc;
                    ram_re     = 1'b1;
                    ram_raddr  = arg[AW-1:0];
                    state_next = BK_OPER;
                end else if (out_free) begin
                    finish     = 1'b1;
                    ir_next    = mem_word;
                    cnt_next   = cnt_inc;
                    state_next = BK_IDLE;
                    priority if (op_ch == CH_H) begin
                        fin_status = ST_HALT;
                        run_next   = 1'b0;
                    end else if (!op_known) begin
                        fin_status = ST_BADOP;
                        run_next   = 1'b0;
                    end else if (!digits_ok) begin
                        fin_status = ST_BADARG;
                        run_next   = 1'b0;
                    end else if (op_ch == CH_B) begin
                        if (tog_reg) begin
                            cnt_next = arg;
                        end
                    end else if ((op_ch == CH_G) || (op_ch == CH_P)) begin
                        if (({1'b0, base} + 8'd10) > MEM_W8) begin
                            fin_status = ST_BADARG;
                            run_next   = 1'b0;
                        end else begin
                            fin_status = (op_ch == CH_G) ? ST_GET : ST_PUT;
                            fin_block  = base;
                        end
                    end else if (arg >= MEM_W7) begin
                        fin_status = ST_BADARG;
                        run_next   = 1'b0;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = arg[AW-1:0];
                        ram_wdata = r_reg;
                        vld_next[arg[AW-1:0]] = 1'b1;
                    end
                end
            end
            BK_OPER: begin
                if (out_free) begin
                    finish     = 1'b1;
                    state_next = BK_IDLE;
                    if (ir_reg[31:24] == CH_L) begin
                        r_next = mem_word;
                    end else begin
                        tog_next = r_reg == mem_word;
                    end
                end
            end
        endcase

        res.status        = fin_status;
        res.data          = fin_read ? fin_rdata : r_next;
        res.block_address = fin_block;
        res.next_counter  = cnt_next;
        res.compare_flag  = tog_next;

        out_valid_next = finish ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= 7'd0;
            r_reg         <= ZERO_CHARS;
            ir_reg        <= ZERO_CHARS;
            tog_reg       <= 1'b0;
            run_reg       <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            r_reg         <= r_next;
            ir_reg        <= ir_next;
            tog_reg       <= tog_next;
            run_reg       <= run_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            vld_rd_reg <= vld_reg[ram_raddr];
        end
        if (finish) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

endmodule

>>> rtl/char_word_cpu_step.sv
// Character-word machine: a front queue of two items feeding an execution back end.
// Results are held in the back end's output register until taken. Throughput: one write per
// cycle while the receiver takes results; a read or step holds off the next item until its
// result is registered. A step fetches the instruction and then, for L and C, reads the operand on the
// single read port. Reset clears control state; every word reads as zero until written
// (per-word valid bits), so no clearing pass follows reset.
module char_word_cpu_step #(
    parameter int MEM_WORDS = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [6:0]  s_address,
    input  logic [31:0] s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_data,
    output logic [6:0]  m_block_address,
    output logic [6:0]  m_next_counter,
    output logic        m_compare_flag
);
    import crw_pkg::*;

    logic cmd_valid, cmd_ready;
    cmd_t cmd_data;
    res_t res;

    crw_front #(.MEM_WORDS(MEM_WORDS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_address   (s_address),
        .s_word      (s_word),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_data    (cmd_data)
    );

    crw_back #(.MEM_WORDS(MEM_WORDS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (res)
    );

    assign m_status        = res.status;
    assign m_data          = res.data;
    assign m_block_address = res.block_address;
    assign m_next_counter  = res.next_counter;
    assign m_compare_flag  = res.compare_flag;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for char_word_cpu_step: a machine-level predictor checks every result.
// Depends on crw_pkg and the char_word_cpu_step RTL only.
module testbench;
    import crw_pkg::*;

    localparam int MEM_WORDS = 100;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [6:0]  s_address;
    logic [31:0] s_word;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [31:0] m_data;
    logic [6:0]  m_block_address;
    logic [6:0]  m_next_counter;
    logic        m_compare_flag;

    logic [31:0] vm_mem [MEM_WORDS];
    logic [31:0] vm_acc;
    int          vm_pc;
    logic        vm_toggle;
    logic        vm_running;

    res_t        awaited_responses[$];
    int          bad_responses;
    int          items_sent;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          sink_hold_request;
    int          sink_hold_left;
    logic [31:0] data_pool [4];

    char_word_cpu_step #(
        .MEM_WORDS(MEM_WORDS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_address       (s_address),
        .s_word          (s_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_data          (m_data),
        .m_block_address (m_block_address),
        .m_next_counter  (m_next_counter),
        .m_compare_flag  (m_compare_flag)
    );

    always #10 aclk = ~aclk;

    function automatic res_t machine_response(input op_t op, input logic [6:0] addr,
                                              input logic [31:0] word);
        res_t        resp;
        logic [31:0] instr;
        logic [7:0]  opc;
        logic        digits_ok;
        int          operand;
        int          base;
        resp = '0;
        resp.status = ST_DONE;
        case (op)
            OP_WRITE: begin
                if (addr < MEM_WORDS) vm_mem[addr] = word;
                else resp.status = ST_BADARG;
            end
            OP_READ: begin
                if (addr < MEM_WORDS) resp.data = vm_mem[addr];
                else resp.status = ST_BADARG;
            end
            OP_STEP: begin
                if (!vm_running) begin
                    resp.status = ST_IDLE;
                end else if (vm_pc >= MEM_WORDS) begin
                    vm_running = 1'b0;
                    resp.status = ST_BADARG;
                end else begin
                    instr = vm_mem[vm_pc];
                    vm_pc++;
                    opc = instr[31:24];
                    digits_ok = instr[15:8] >= CH_ZERO && instr[15:8] <= CH_NINE &&
                                instr[7:0] >= CH_ZERO && instr[7:0] <= CH_NINE;
                    operand = int'(instr[15:8] - CH_ZERO) * 10 + int'(instr[7:0] - CH_ZERO);
                    if (opc == CH_H) begin
                        vm_running = 1'b0;
                        resp.status = ST_HALT;
                    end else if (opc != CH_L && opc != CH_S && opc != CH_C && opc != CH_B &&
                                 opc != CH_G && opc != CH_P) begin
                        vm_running = 1'b0;
                        resp.status = ST_BADOP;
                    end else if (!digits_ok) begin
                        vm_running = 1'b0;
                        resp.status = ST_BADARG;
                    end else if (opc == CH_B) begin
                        if (vm_toggle) vm_pc = operand;
                    end else if (opc == CH_G || opc == CH_P) begin
                        base = operand - operand % int'(BLOCK_WORDS);
                        if (base + int'(BLOCK_WORDS) > MEM_WORDS) begin
                            vm_running = 1'b0;
                            resp.status = ST_BADARG;
                        end else begin
                            resp.block_address = 7'(base);
                            resp.status = (opc == CH_G) ? ST_GET : ST_PUT;
                        end
                    end else if (operand >= MEM_WORDS) begin
                        vm_running = 1'b0;
                        resp.status = ST_BADARG;
                    end else if (opc == CH_L) begin
                        vm_acc = vm_mem[operand];
                    end else if (opc == CH_S) begin
                        vm_mem[operand] = vm_acc;
                    end else begin
                        vm_toggle = (vm_acc == vm_mem[operand]);
                    end
                end
            end
            default: begin
                vm_pc = 0;
                vm_running = 1'b1;
            end
        endcase
        if (op != OP_READ) resp.data = vm_acc;
        resp.next_counter = 7'(vm_pc);
        resp.compare_flag = vm_toggle;
        return resp;
    endfunction

    function automatic logic [31:0] instr_word(input logic [7:0] opc, input int operand);
        return {opc, CH_ZERO, 8'(CH_ZERO + operand / 10), 8'(CH_ZERO + operand % 10)};
    endfunction

    function automatic logic [31:0] random_instr();
        logic [7:0]  opc;
        logic [31:0] w;
        int          operand;
        case ($urandom_range(24))
            0:                opc = CH_H;
            1, 2:             opc = 8'($urandom);
            3, 4, 5, 6:       opc = CH_L;
            7, 8, 9, 10:      opc = CH_S;
            11, 12, 13, 14:   opc = CH_C;
            15, 16, 17, 18:   opc = CH_B;
            19, 20, 21:       opc = CH_G;
            default:          opc = CH_P;
        endcase
        operand = ($urandom_range(1) == 1) ? $urandom_range(99, 90) : $urandom_range(99);
        w = instr_word(opc, operand);
        w[23:16] = 8'($urandom);
        if ($urandom_range(19) == 0) w[15:8] = 8'($urandom);
        if ($urandom_range(19) == 0) w[7:0] = 8'($urandom);
        return w;
    endfunction

    function automatic logic [6:0] any_address();
        return ($urandom_range(9) == 0) ? 7'($urandom_range(127, 100)) : 7'($urandom_range(99));
    endfunction

    task automatic send_item(input op_t op, input logic [6:0] addr, input logic [31:0] word);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_address   <= addr;
        s_word      <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        awaited_responses.push_back(machine_response(op, addr, word));
        items_sent++;
    endtask

    task automatic send_step();
        send_item(OP_STEP, 7'($urandom), $urandom);
    endtask

    task automatic send_start();
        send_item(OP_START, 7'($urandom), $urandom);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic log_bad_response(input string what, input res_t want, input res_t got);
        bad_responses++;
        if (bad_responses <= 10) begin
            $display("ERROR %s at %0t: expected status %0d data %h block %0d counter %0d flag %b",
                     what, $time, want.status, want.data, want.block_address,
                     want.next_counter, want.compare_flag);
            $display("      got status %0d data %h block %0d counter %0d flag %b",
                     got.status, got.data, got.block_address, got.next_counter,
                     got.compare_flag);
        end
    endtask

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            got.status        = m_status;
            got.data          = m_data;
            got.block_address = m_block_address;
            got.next_counter  = m_next_counter;
            got.compare_flag  = m_compare_flag;
            if (awaited_responses.size() == 0) begin
                want = 'x;
                log_bad_response("unexpected transfer", want, got);
            end else begin
                want = awaited_responses.pop_front();
                if (got.status !== want.status || got.data !== want.data ||
                    got.block_address !== want.block_address ||
                    got.next_counter !== want.next_counter ||
                    got.compare_flag !== want.compare_flag) begin
                    log_bad_response("field differs", want, got);
                end
            end
        end
    end

    // hold off for a requested stretch, otherwise stall at random
    always @(negedge aclk) begin
        if (sink_hold_left == 0 && sink_hold_request != 0) begin
            sink_hold_left = sink_hold_request;
            sink_hold_request = 0;
        end
        if (sink_hold_left != 0) begin
            m_ready <= 1'b0;
            sink_hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic test_directed_program();
        send_item(OP_READ, 7'd127, 32'd0);
        send_item(OP_WRITE, 7'd127, 32'hFFFF_FFFF);
        send_item(OP_WRITE, 7'd60, 32'hFFFF_FFFF);
        send_start();
        send_step();
        send_item(OP_WRITE, 7'd0, instr_word(CH_L, 60));
        send_item(OP_WRITE, 7'd1, {CH_C, 8'h7E, 8'h36, CH_ZERO});
        send_item(OP_WRITE, 7'd2, instr_word(CH_S, 50));
        send_item(OP_WRITE, 7'd3, instr_word(CH_G, 95));
        send_item(OP_WRITE, 7'd4, instr_word(CH_P, 9));
        send_item(OP_WRITE, 7'd5, instr_word(CH_B, 99));
        send_item(OP_WRITE, 7'd99, instr_word(CH_S, 99));
        send_item(OP_START, 7'h7F, 32'hFFFF_FFFF);
        repeat (4) send_step();
        send_item(OP_READ, 7'd50, 32'd0);
        // branch to the last word, then run off the end of memory
        repeat (4) send_step();
        send_item(OP_WRITE, 7'd0, {CH_H, 8'hFF, 8'h00, 8'h7F});
        send_start();
        repeat (2) send_step();
        send_item(OP_WRITE, 7'd0, {CH_L, CH_ZERO, 8'h3A, 8'h35});
        send_start();
        send_step();
    endtask

    task automatic test_random_programs(input int item_budget);
        int stop_at;
        int len;
        int steps;
        stop_at = items_sent + item_budget;
        while (items_sent < stop_at) begin
            len = $urandom_range(16, 3);
            for (int a = 0; a < len; a++) send_item(OP_WRITE, 7'(a), random_instr());
            repeat ($urandom_range(4, 1)) begin
                send_item(OP_WRITE, 7'($urandom_range(99, 90)), data_pool[$urandom_range(3)]);
            end
            send_start();
            steps = 0;
            while (vm_running && steps < 48) begin
                if ($urandom_range(9) == 0) send_item(op_t'($urandom_range(3)), any_address(),
                                                      $urandom);
                else send_step();
                steps++;
            end
            if ($urandom_range(3) == 0) send_step();
        end
    endtask

    task automatic test_receiver_hold();
        sink_hold_request = 400;
        test_random_programs(80);
    endtask

    initial begin
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_operation       = OP_WRITE;
        s_address         = 7'd0;
        s_word            = 32'd0;
        m_ready           = 1'b0;
        bad_responses     = 0;
        items_sent        = 0;
        sink_hold_request = 0;
        sink_hold_left    = 0;
        vm_acc            = ZERO_CHARS;
        vm_pc             = 0;
        vm_toggle         = 1'b0;
        vm_running        = 1'b0;
        for (int i = 0; i < MEM_WORDS; i++) vm_mem[i] = 32'd0;
        data_pool[0] = ZERO_CHARS;
        for (int i = 1; i < 4; i++) data_pool[i] = $urandom;

        src_idle_pct   = 19;
        sink_stall_pct = 58;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_program();
        test_random_programs(480);
        wait_idle();

        src_idle_pct   = 58;
        sink_stall_pct = 19;
        test_random_programs(480);
        wait_idle();

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_receiver_hold();
        test_random_programs(480);
        wait_idle();

        if (bad_responses == 0) begin
            $display("char_word_cpu_step: match");
        end else begin
            $display("char_word_cpu_step: mismatch");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("char_word_cpu_step: mismatch");
        $finish;
    end

endmodule
